// File: hw/rtl/lat_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lat_pkg;

   localparam int ADDR_W    = 48;
   localparam int TIME_W    = 32;
   localparam int SLOT_W    = 4;
   localparam int CNT_OUT_W = 5;

   localparam logic MODE_ACCESS = 1'b0;
   localparam logic MODE_REMOVE = 1'b1;

   typedef struct packed {
      logic              mode;
      logic [ADDR_W-1:0] station_addr;
      logic [TIME_W-1:0] now_ms;
   } req_type;

   typedef struct packed {
      logic                 hit;
      logic                 inserted;
      logic                 evicted;
      logic [ADDR_W-1:0]    evicted_addr;
      logic                 removed;
      logic [SLOT_W-1:0]    slot;
      logic [CNT_OUT_W-1:0] entry_count;
   } rsp_type;

endpackage

`default_nettype wire

// File: hw/rtl/lru_address_table_unit.sv
// LRU station address table.
// Request channel (req_valid / req_stall / req_word): one word per table operation,
// mode access (look up, refresh or insert) or remove. Response channel
// (rsp_valid / rsp_stall / rsp_word): exactly one word per request, in order.
// Addresses and time stamps sit in one synchronous RAM with a single read port;
// valid marks and the entry count are in flops.
// Each request walks the RAM once, one entry per cycle, collecting the first
// matching slot, the first free slot and the oldest valid entry, then does a
// single write-back. A request passes the scan, wait and update states on its
// way to the response register, and req_stall stays high until it is back in
// idle, so the next request is taken only after that; the RAM scan sets the pace.
// Reset (synchronous) clears all valid marks and the count at once; the RAM is
// not cleared and no sweep is needed, since invalid slots are never trusted.
// The result sits in an output register; while an earlier result is still held
// by rsp_stall, a done write-back waits in the update state; req_stall stays high.
`timescale 1ns / 1ps
`default_nettype none

module lru_address_table_unit #(
   parameter int ENTRIES = 16
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire lat_pkg::req_type req_word,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output lat_pkg::rsp_type      rsp_word
);

   import lat_pkg::*;

   localparam int IDX_W   = $clog2(ENTRIES);
   localparam int COUNT_W = $clog2(ENTRIES + 1);
   localparam int WORD_W  = ADDR_W + TIME_W;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_SCAN   = 4'b0010,
      ST_WAIT   = 4'b0100,
      ST_UPDATE = 4'b1000
   } state_type;

   // table RAM: {address, last use}
   logic [WORD_W-1:0] table_mem [ENTRIES];

   state_type          state_ff, state_in;
   logic [IDX_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic               rd_pend_ff;
   logic [IDX_W-1:0]   rd_idx_ff;
   logic [WORD_W-1:0]  rd_data_ff;
   logic [ENTRIES-1:0] valid_ff, valid_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;
   req_type            req_ff;

   // scan accumulators
   logic               match_ff, match_in;
   logic [IDX_W-1:0]   match_idx_ff, match_idx_in;
   logic               free_ff, free_in;
   logic [IDX_W-1:0]   free_idx_ff, free_idx_in;
   logic               old_ff, old_in;
   logic [IDX_W-1:0]   old_idx_ff, old_idx_in;
   logic [TIME_W-1:0]  old_ts_ff, old_ts_in;
   logic [ADDR_W-1:0]  old_addr_ff, old_addr_in;

   logic               accept;
   logic               rd_en;
   logic               out_free;
   logic               commit;
   logic               wr_en;
   logic [IDX_W-1:0]   wr_idx;
   logic [ADDR_W-1:0]  rd_addr;
   logic [TIME_W-1:0]  rd_ts;
   logic               rd_valid;
   logic               full;
   logic [IDX_W-1:0]   slot_idx;
   logic [SLOT_W+IDX_W-1:0]     slot_ext;
   logic [CNT_OUT_W+COUNT_W-1:0] count_ext;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign rd_en     = (state_ff == ST_SCAN);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign commit    = (state_ff == ST_UPDATE) && out_free;
   assign full      = (count_ff == COUNT_W'(ENTRIES));

   assign rd_addr  = rd_data_ff[WORD_W-1:TIME_W];
   assign rd_ts    = rd_data_ff[TIME_W-1:0];
   assign rd_valid = valid_ff[rd_idx_ff];

   // sequencer
   always_comb begin
      state_in  = state_ff;
      rd_ptr_in = rd_ptr_ff;
      case (state_ff)
         ST_IDLE: begin
            rd_ptr_in = '0;
            if (accept) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            rd_ptr_in = rd_ptr_ff + 1'b1;
            if (rd_ptr_ff == IDX_W'(ENTRIES - 1)) begin
               state_in = ST_WAIT;
            end
         end
         ST_WAIT: begin
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // fold each returned entry into the accumulators
   always_comb begin
      match_in     = match_ff;
      match_idx_in = match_idx_ff;
      free_in      = free_ff;
      free_idx_in  = free_idx_ff;
      old_in       = old_ff;
      old_idx_in   = old_idx_ff;
      old_ts_in    = old_ts_ff;
      old_addr_in  = old_addr_ff;
      if (accept) begin
         match_in = 1'b0;
         free_in  = 1'b0;
         old_in   = 1'b0;
      end else if (rd_pend_ff) begin
         if (rd_valid && !match_ff && rd_addr == req_ff.station_addr) begin
            match_in     = 1'b1;
            match_idx_in = rd_idx_ff;
         end
         if (!rd_valid && !free_ff) begin
            free_in     = 1'b1;
            free_idx_in = rd_idx_ff;
         end
         // strict less keeps the lowest slot on ties
         if (rd_valid && (!old_ff || rd_ts < old_ts_ff)) begin
            old_in      = 1'b1;
            old_idx_in  = rd_idx_ff;
            old_ts_in   = rd_ts;
            old_addr_in = rd_addr;
         end
      end
   end

   // write-back decision
   always_comb begin
      valid_in = valid_ff;
      count_in = count_ff;
      wr_en    = 1'b0;
      wr_idx   = match_idx_ff;
      slot_idx = '0;
      rsp_in   = '0;
      if (req_ff.mode == MODE_ACCESS) begin
         if (match_ff) begin
            wr_en      = 1'b1;
            slot_idx   = match_idx_ff;
            rsp_in.hit = 1'b1;
         end else if (full) begin
            // evicted slot is the only free one afterwards
            wr_en               = 1'b1;
            wr_idx              = old_idx_ff;
            slot_idx            = old_idx_ff;
            rsp_in.inserted     = 1'b1;
            rsp_in.evicted      = old_ff;
            rsp_in.evicted_addr = old_addr_ff;
         end else begin
            wr_en            = 1'b1;
            wr_idx           = free_idx_ff;
            slot_idx         = free_idx_ff;
            valid_in[free_idx_ff] = 1'b1;
            count_in         = count_ff + 1'b1;
            rsp_in.inserted  = 1'b1;
         end
      end else if (match_ff) begin
         valid_in[match_idx_ff] = 1'b0;
         count_in               = count_ff - 1'b1;
         slot_idx               = match_idx_ff;
         rsp_in.removed         = 1'b1;
      end
      slot_ext           = {{SLOT_W{1'b0}}, slot_idx};
      count_ext          = {{CNT_OUT_W{1'b0}}, count_in};
      rsp_in.slot        = slot_ext[SLOT_W-1:0];
      rsp_in.entry_count = count_ext[CNT_OUT_W-1:0];
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (commit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // RAM: one read, one write port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= table_mem[rd_ptr_ff];
      end
      if (commit && wr_en) begin
         table_mem[wr_idx] <= {req_ff.station_addr, req_ff.now_ms};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rd_ptr_ff    <= '0;
         rd_pend_ff   <= 1'b0;
         valid_ff     <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rd_ptr_ff    <= rd_ptr_in;
         rd_pend_ff   <= rd_en;
         rsp_valid_ff <= rsp_valid_in;
         if (commit) begin
            valid_ff <= valid_in;
            count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff    <= rd_ptr_ff;
      match_ff     <= match_in;
      match_idx_ff <= match_idx_in;
      free_ff      <= free_in;
      free_idx_ff  <= free_idx_in;
      old_ff       <= old_in;
      old_idx_ff   <= old_idx_in;
      old_ts_ff    <= old_ts_in;
      old_addr_ff  <= old_addr_in;
      if (accept) begin
         req_ff <= req_word;
      end
      if (commit) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

   // count tracks the valid marks
   a_count_marks: assert property (@(posedge clock) disable iff (reset)
      count_ff == COUNT_W'($countones(valid_ff)))
      else $error("entry count out of step with valid marks");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_W'(ENTRIES))
      else $error("entry count above table size");

   a_one_outcome: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $onehot0({rsp_ff.hit, rsp_ff.inserted, rsp_ff.removed}))
      else $error("more than one outcome in a response word");

   a_evict_insert: assert property (@(posedge clock) disable iff (reset)
      commit && rsp_in.evicted |-> rsp_in.inserted && full)
      else $error("eviction without a full table and insert");

   a_accept_scan: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == ST_SCAN)
      else $error("accepted word did not start a scan");

endmodule

`default_nettype wire

// File: dv/testbench.sv
`timescale 1ns / 1ps

module testbench;
   import lat_pkg::*;

   // table depth as built into the unit (default parameter)
   localparam int TBL_SLOTS   = 16;
   // RAM scan of all slots plus write-back; margin for the end of the run
   localparam int SETTLE      = 60;
   // receiver hold-off used to back the unit up
   localparam int LONG_HOLD   = 400;
   // cycles with no word moving on either channel before giving up
   localparam int STUCK_LIMIT = 5000;
   localparam int PHASE_WORDS = 670;
   localparam int POOL_SIZE   = 24;
   localparam int REPORT_MAX  = 10;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_word  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_word;

   lru_address_table_unit uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   always #1 clock = ~clock;

   // ---------------------------------------------------------------
   // Shadow copy of the station table
   // ---------------------------------------------------------------
   logic [ADDR_W-1:0] tbl_addr  [TBL_SLOTS];
   bit                tbl_live  [TBL_SLOTS];
   logic [TIME_W-1:0] tbl_stamp [TBL_SLOTS];
   int                live_count = 0;

   // responses still owed by the unit, oldest first
   rsp_type pending_outcomes[$];

   int send_idle_pct = 0;
   int rcv_idle_pct  = 0;
   int hold_requests = 0;
   int mismatch_count = 0;

   // One table operation: lowest valid match wins; a miss on a full table
   // throws out the oldest stamp (lowest slot on a tie), then the address
   // lands in the lowest free slot. Removes touch no stamps.
   function automatic rsp_type table_outcome(req_type w);
      rsp_type r;
      int      match;
      int      oldest;
      int      free_slot;
      r = '0;
      match = -1;
      oldest = -1;
      free_slot = -1;
      for (int i = 0; i < TBL_SLOTS; i++)
         if (match < 0 && tbl_live[i] && tbl_addr[i] == w.station_addr)
            match = i;
      if (w.mode == MODE_ACCESS) begin
         if (match >= 0) begin
            tbl_stamp[match] = w.now_ms;
            r.hit  = 1'b1;
            r.slot = match[SLOT_W-1:0];
         end else begin
            if (live_count >= TBL_SLOTS) begin
               for (int i = 0; i < TBL_SLOTS; i++)
                  if (tbl_live[i] && (oldest < 0 || tbl_stamp[i] < tbl_stamp[oldest]))
                     oldest = i;
               if (oldest >= 0) begin
                  tbl_live[oldest] = 1'b0;
                  live_count--;
                  r.evicted      = 1'b1;
                  r.evicted_addr = tbl_addr[oldest];
               end
            end
            for (int i = 0; i < TBL_SLOTS; i++)
               if (free_slot < 0 && !tbl_live[i])
                  free_slot = i;
            if (free_slot >= 0) begin
               tbl_addr[free_slot]  = w.station_addr;
               tbl_stamp[free_slot] = w.now_ms;
               tbl_live[free_slot]  = 1'b1;
               live_count++;
               r.inserted = 1'b1;
               r.slot     = free_slot[SLOT_W-1:0];
            end
         end
      end else if (match >= 0) begin
         tbl_live[match] = 1'b0;
         if (live_count > 0)
            live_count--;
         r.removed = 1'b1;
         r.slot    = match[SLOT_W-1:0];
      end
      r.entry_count = live_count[CNT_OUT_W-1:0];
      return r;
   endfunction

   // ---------------------------------------------------------------
   // Sender side
   // ---------------------------------------------------------------
   // Offer one word, with random idle cycles ahead of it. Valid is only
   // dropped for a gap, so back-to-back words keep it high.
   // On acceptance the expectation is queued: the typed-in one where the
   // row has it, else the shadow table's answer (the shadow always steps).
   task automatic offer_word(input req_type w, input bit fixed, input rsp_type fixed_rsp);
      rsp_type predicted;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word  <= w;
      do
         @(posedge clock);
      while (req_stall);
      predicted = table_outcome(w);
      pending_outcomes.push_back(fixed ? fixed_rsp : predicted);
   endtask

   // Hold the sender off until every owed response is back.
   task automatic drain_outcomes();
      req_valid <= 1'b0;
      while (pending_outcomes.size() != 0)
         @(posedge clock);
      @(posedge clock);
   endtask

   // ---------------------------------------------------------------
   // Directed rows
   // ---------------------------------------------------------------
   typedef struct {
      req_type word;
      bit      fixed;
      rsp_type outcome;
   } drill_row;

   drill_row drills[$];

   task automatic add_row(input logic mode, input logic [ADDR_W-1:0] addr,
                          input logic [TIME_W-1:0] now, input bit fixed,
                          input rsp_type outcome);
      drill_row row;
      row.word    = '{mode: mode, station_addr: addr, now_ms: now};
      row.fixed   = fixed;
      row.outcome = outcome;
      drills.push_back(row);
   endtask

   // ---------------------------------------------------------------
   // Random words: mostly a small pool of stations so that hits, removes
   // and evictions keep coming; time mostly creeps forward (repeats give
   // stamp ties), with the odd jump, zero or all-ones.
   // ---------------------------------------------------------------
   logic [ADDR_W-1:0] station_pool[POOL_SIZE];
   logic [TIME_W-1:0] wall_ms = '0;

   function automatic logic [ADDR_W-1:0] any_station();
      logic [63:0] raw;
      raw = {$urandom, $urandom};
      return raw[ADDR_W-1:0];
   endfunction

   function automatic req_type random_request();
      req_type w;
      int      pick;
      w.mode = ($urandom_range(3) == 0) ? MODE_REMOVE : MODE_ACCESS;
      w.station_addr = ($urandom_range(9) == 0) ? any_station()
                                                : station_pool[$urandom_range(POOL_SIZE-1)];
      wall_ms = wall_ms + TIME_W'($urandom_range(50));
      pick = $urandom_range(39);
      if (pick == 0)
         w.now_ms = '0;
      else if (pick == 1)
         w.now_ms = '1;
      else if (pick < 4)
         w.now_ms = $urandom;
      else
         w.now_ms = wall_ms;
      return w;
   endfunction

   // ---------------------------------------------------------------
   // Receiver: checks each word taken, and drives its own stall, with a
   // long hold-off on request from the main thread.
   // ---------------------------------------------------------------
   int hold_served = 0;
   int hold_left   = 0;

   task automatic compare_field(input string name, input logic [ADDR_W-1:0] want,
                                input logic [ADDR_W-1:0] got);
      if (want !== got) begin
         if (mismatch_count < REPORT_MAX)
            $display("tb: %s mismatch at %0t: expected %h, got %h", name, $realtime, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin : rsp_side
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_outcomes.size() == 0) begin
            if (mismatch_count < REPORT_MAX)
               $display("tb: unexpected response word at %0t: %p", $realtime, rsp_word);
            mismatch_count++;
         end else begin
            want = pending_outcomes.pop_front();
            compare_field("hit",          want.hit,          rsp_word.hit);
            compare_field("inserted",     want.inserted,     rsp_word.inserted);
            compare_field("evicted",      want.evicted,      rsp_word.evicted);
            compare_field("evicted_addr", want.evicted_addr, rsp_word.evicted_addr);
            compare_field("removed",      want.removed,      rsp_word.removed);
            compare_field("slot",         want.slot,         rsp_word.slot);
            compare_field("entry_count",  want.entry_count,  rsp_word.entry_count);
         end
      end
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (hold_served != hold_requests) begin
         rsp_stall   <= 1'b1;
         hold_left   <= LONG_HOLD;
         hold_served <= hold_requests;
      end else begin
         rsp_stall <= ($urandom_range(99) < rcv_idle_pct);
      end
   end

   // Watchdog: a stretch with no word moving either way means a hang.
   int stuck_cycles = 0;

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         stuck_cycles <= 0;
      else
         stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles >= STUCK_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // ---------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------
   initial begin
      // empty table, extremes of address and time, hit, remove hit/miss
      add_row(MODE_REMOVE, '0, '0, 1'b1, rsp_type'{0, 0, 0, '0, 0, 0, 0});
      add_row(MODE_ACCESS, '0, '0, 1'b1, rsp_type'{0, 1, 0, '0, 0, 0, 1});
      add_row(MODE_ACCESS, '1, '1, 1'b1, rsp_type'{0, 1, 0, '0, 0, 1, 2});
      add_row(MODE_ACCESS, '0, 32'd5, 1'b1, rsp_type'{1, 0, 0, '0, 0, 0, 2});
      add_row(MODE_REMOVE, '1, 32'd3, 1'b1, rsp_type'{0, 0, 0, '0, 1, 1, 1});
      add_row(MODE_REMOVE, '1, 32'd3, 1'b1, rsp_type'{0, 0, 0, '0, 0, 0, 1});
      // fill slots 1..15, all stamped 7
      for (int i = 1; i < TBL_SLOTS; i++)
         add_row(MODE_ACCESS, 48'h0000_0000_0100 + ADDR_W'(i), 32'd7, 1'b0, '0);
      // full table: slot 0 (stamp 5) is the oldest and goes
      add_row(MODE_ACCESS, 48'h0A0A_0000_0001, 32'd9, 1'b1, rsp_type'{0, 1, 1, '0, 0, 0, 16});
      // tie among stamps of 7: lowest slot goes; new entry stamped zero
      add_row(MODE_ACCESS, 48'h0A0A_0000_0002, '0, 1'b0, '0);
      // stamp zero is simply the smallest
      add_row(MODE_ACCESS, 48'h0A0A_0000_0003, 32'd1, 1'b0, '0);
      add_row(MODE_ACCESS, '1, '1, 1'b0, '0);

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      foreach (drills[n])
         offer_word(drills[n].word, drills[n].fixed, drills[n].outcome);
      drain_outcomes();

      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin send_idle_pct = 7;  rcv_idle_pct = 45; end
            1: begin send_idle_pct = 45; rcv_idle_pct = 7;  end
            default: begin send_idle_pct = 0; rcv_idle_pct = 0; end
         endcase
         foreach (station_pool[k])
            station_pool[k] = any_station();
         for (int n = 0; n < PHASE_WORDS; n++) begin
            // back the unit up: receiver sits on its stall while words keep coming
            if (n == 50)
               hold_requests <= hold_requests + 1;
            // sender waits for every owed response mid-phase
            if (n == PHASE_WORDS / 2)
               drain_outcomes();
            offer_word(random_request(), 1'b0, '0);
         end
         drain_outcomes();
      end

      repeat (SETTLE) @(posedge clock);
      if (mismatch_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
